### rtl/core/srp_pkg.sv
// Package: shared types and constants for the scan rate pacer.
`default_nettype none

package srp_pkg;

	// field and register widths
	localparam int unsigned COUNT_W   = 40;
	localparam int unsigned NOW_W     = 48;
	localparam int unsigned PIDX_W    = 13;
	localparam int unsigned RATE_W    = 20;
	localparam int unsigned SLEEP_W   = 20;
	localparam int unsigned LIMIT_W   = 24;
	localparam int unsigned CFG_W     = 24;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned ALU_W     = 64;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RATE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SLEEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLEEP = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STREAK    = 2'd3;

	// register reset values
	localparam logic [RATE_W-1:0]  RST_RATE      = 20'd0;
	localparam logic [SLEEP_W-1:0] RST_MIN_SLEEP = 20'd1000;
	localparam logic [SLEEP_W-1:0] RST_MAX_SLEEP = 20'd10000;
	localparam logic [LIMIT_W-1:0] RST_STREAK    = 24'd200000;

	// one million = 15625 * 2^6: multiply by the odd part, then shift
	localparam int unsigned        MUL_STEPS  = 14;
	localparam logic [MUL_STEPS-1:0] MULT_K   = 14'd15625;
	localparam int unsigned        MULT_SHIFT = 6;

	// dividend (count delta * 1e6) is below 2^60
	localparam int unsigned DIV_STEPS = 60;
	localparam int unsigned STEP_W    = 6;

	typedef enum logic [0:0] {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		logic [ALU_W-1:0] sum;
		logic             borrow;
		logic             zero;
	} alu_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INC,
		ST_DELTA,
		ST_MUL,
		ST_DIV,
		ST_ELAP,
		ST_AHEAD,
		ST_MIN,
		ST_MAX,
		ST_STRK,
		ST_LIM,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

### rtl/core/srp_if.sv
// Interfaces: item and result channels of the scan rate pacer.
`default_nettype none

interface srp_item_if;
	logic        valid;
	logic        ready;
	logic [47:0] now_us;
	logic        from_base_worker;
	logic [12:0] partition_index;

	modport source (output valid, output now_us, output from_base_worker,
		output partition_index, input ready);
	modport sink (input valid, input now_us, input from_base_worker,
		input partition_index, output ready);
endinterface

interface srp_result_if;
	logic        valid;
	logic        ready;
	logic [19:0] pause_us;
	logic        add_worker;
	logic        add_all_workers;
	logic [39:0] items_counted;

	modport source (output valid, output pause_us, output add_worker,
		output add_all_workers, output items_counted, input ready);
	modport sink (input valid, input pause_us, input add_worker,
		input add_all_workers, input items_counted, output ready);
endinterface

`default_nettype wire

### rtl/core/srp_alu.sv
// Shared 64-bit add/subtract unit with borrow and zero flags.
`default_nettype none

module srp_alu (
	input  wire srp_pkg::alu_op_t             op,
	input  wire logic [srp_pkg::ALU_W-1:0]    a,
	input  wire logic [srp_pkg::ALU_W-1:0]    b,
	output srp_pkg::alu_res_t                 res
);
	import srp_pkg::*;

	logic [ALU_W:0] wide;
	logic [ALU_W-1:0] b_eff;

	// subtract as a + ~b + 1; a missing carry out is a borrow
	always_comb begin
		b_eff = (op == ALU_SUB) ? ~b : b;
		wide = {1'b0, a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, (op == ALU_SUB)};
		res.sum = wide[ALU_W-1:0];
		res.borrow = (op == ALU_SUB) ? ~wide[ALU_W] : 1'b0;
		res.zero = (wide[ALU_W-1:0] == '0);
	end

endmodule

`default_nettype wire

### rtl/core/scan_rate_pacer.sv
// Top level: scan rate pacer, sequencer around one shared add/subtract unit.
//
//   channel | dir | handshake     | payload
//   item    | in  | valid / ready | now_us, from_base_worker, partition_index
//   result  | out | valid / ready | pause_us, add_worker, add_all_workers, items_counted
//   cfg     | in  | cfg_we        | cfg_index, cfg_data
//
// A paced item runs 14 shift-add steps for the count delta times one million,
// 60 restoring division steps by the rate, and the compare steps, all through
// the one 64-bit adder. An unpaced item goes from the count increment to the output step.
// Reset clears the count, base point and streak and loads register defaults.
// A result waits in the output register; a stalled result holds the sequencer
// in its last step until the register frees up.
`default_nettype none

module scan_rate_pacer #(
	parameter int PARTITIONS = 4096,
	parameter int TIME_BITS  = 48
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [srp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [srp_pkg::CFG_W-1:0]        cfg_data,
	srp_item_if.sink                              item,
	srp_result_if.source                          result
);
	import srp_pkg::*;

	localparam int TW = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;
	localparam int PART_W = 17;
	localparam logic [PART_W-1:0] LAST_PART = PART_W'(PARTITIONS - 1);
	localparam logic WIDE_TIME = (TIME_BITS > TW);

	// configuration registers
	logic [RATE_W-1:0]  rate_q;
	logic [SLEEP_W-1:0] min_q;
	logic [SLEEP_W-1:0] max_q;
	logic [LIMIT_W-1:0] limit_q;

	// pacing state
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] base_count_q;
	logic [TW-1:0]      base_time_q;
	logic [TW-1:0]      streak_q;

	// per-item working registers
	logic [TW-1:0]      now_q;
	logic               base_q;
	logic               near_q;
	logic [COUNT_W-1:0] delta_q;
	logic [ALU_W-1:0]   acc_q;
	logic [RATE_W-1:0]  rem_q;
	logic [ALU_W-1:0]   elap_q;
	logic               ge_q;
	logic [ALU_W-1:0]   ahead_q;
	logic [TW-1:0]      diff_q;
	logic               grt_q;
	logic [STEP_W-1:0]  step_q;
	logic [SLEEP_W-1:0] sleep_q;
	logic               add_one_q;
	logic               add_all_q;

	// output register
	logic               out_valid_q;
	logic [SLEEP_W-1:0] out_sleep_q;
	logic               out_one_q;
	logic               out_all_q;
	logic [COUNT_W-1:0] out_count_q;

	state_t state_q, state_d;
	alu_op_t alu_op;
	logic [ALU_W-1:0] alu_a, alu_b;
	alu_res_t alu_res;
	logic item_beat, out_load, streak_hit;

	srp_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	assign item.ready = (state_q == ST_IDLE);
	assign item_beat = item.valid && item.ready;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || result.ready);
	assign streak_hit = grt_q || alu_res.borrow;

	assign result.valid = out_valid_q;
	assign result.pause_us = out_sleep_q;
	assign result.add_worker = out_one_q;
	assign result.add_all_workers = out_all_q;
	assign result.items_counted = out_count_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and adder operand select
	always_comb begin
		state_d = state_q;
		alu_op = ALU_SUB;
		alu_a = '0;
		alu_b = '0;
		case (state_q)
			ST_IDLE: begin
				if (item_beat) state_d = ST_INC;
			end
			ST_INC: begin
				alu_op = ALU_ADD;
				alu_a = ALU_W'(count_q);
				alu_b = ALU_W'(1);
				state_d = (rate_q == '0) ? ST_OUT : ST_DELTA;
			end
			ST_DELTA: begin
				alu_a = ALU_W'(count_q);
				alu_b = ALU_W'(base_count_q);
				state_d = ST_MUL;
			end
			ST_MUL: begin
				alu_op = ALU_ADD;
				alu_a = {acc_q[ALU_W-2:0], 1'b0};
				alu_b = MULT_K[step_q[3:0]] ? ALU_W'(delta_q) : '0;
				if (step_q == '0) state_d = ST_DIV;
			end
			ST_DIV: begin
				alu_a = ALU_W'({rem_q, acc_q[DIV_STEPS-1]});
				alu_b = ALU_W'(rate_q);
				if (step_q == '0) state_d = ST_ELAP;
			end
			ST_ELAP: begin
				alu_a = ALU_W'(now_q);
				alu_b = ALU_W'(base_time_q);
				state_d = ST_AHEAD;
			end
			ST_AHEAD: begin
				// quotient sits in the low bits, leftover dividend bits above it
				alu_a = ALU_W'(acc_q[DIV_STEPS-1:0]);
				alu_b = elap_q;
				state_d = (ge_q && (alu_res.borrow || alu_res.zero)) ? ST_STRK : ST_MIN;
			end
			ST_MIN: begin
				alu_a = ALU_W'(min_q);
				alu_b = ahead_q;
				state_d = alu_res.borrow ? ST_MAX : ST_STRK;
			end
			ST_MAX: begin
				alu_a = ALU_W'(max_q);
				alu_b = ahead_q;
				state_d = ST_STRK;
			end
			ST_STRK: begin
				alu_a = ALU_W'(now_q);
				alu_b = ALU_W'(streak_q);
				if (base_q && !near_q && (sleep_q == '0) && (streak_q != '0)) begin
					state_d = ST_LIM;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_LIM: begin
				alu_a = ALU_W'(limit_q);
				alu_b = ALU_W'(diff_q);
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RST_RATE;
			min_q <= RST_MIN_SLEEP;
			max_q <= RST_MAX_SLEEP;
			limit_q <= RST_STREAK;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RATE: rate_q <= cfg_data[RATE_W-1:0];
				CFG_MIN_SLEEP: min_q <= cfg_data[SLEEP_W-1:0];
				CFG_MAX_SLEEP: max_q <= cfg_data[SLEEP_W-1:0];
				CFG_STREAK: limit_q <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// pacing state: count, base point, streak
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			base_count_q <= '0;
			base_time_q <= '0;
			streak_q <= '0;
		end else begin
			case (state_q)
				ST_INC: count_q <= alu_res.sum[COUNT_W-1:0];
				ST_MAX: streak_q <= '0;
				ST_STRK: begin
					if (base_q && !near_q && (sleep_q == '0) && (streak_q == '0)) begin
						streak_q <= now_q;
					end
				end
				ST_LIM: begin
					if (streak_hit) begin
						streak_q <= '0;
						base_time_q <= now_q;
						base_count_q <= count_q;
					end
				end
				default: ;
			endcase
		end
	end

	// working registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_beat) begin
					now_q <= item.now_us[TW-1:0];
					base_q <= item.from_base_worker;
					near_q <= (PART_W'(item.partition_index) >= LAST_PART);
				end
			end
			ST_INC: begin
				sleep_q <= '0;
				add_one_q <= 1'b0;
				add_all_q <= (rate_q == '0) && base_q && !near_q;
			end
			ST_DELTA: begin
				delta_q <= alu_res.sum[COUNT_W-1:0];
				acc_q <= '0;
				step_q <= STEP_W'(MUL_STEPS - 1);
			end
			ST_MUL: begin
				if (step_q == '0) begin
					acc_q <= alu_res.sum << MULT_SHIFT;
					rem_q <= '0;
					step_q <= STEP_W'(DIV_STEPS - 1);
				end else begin
					acc_q <= alu_res.sum;
					step_q <= step_q - STEP_W'(1);
				end
			end
			ST_DIV: begin
				// restore on borrow, else keep the difference
				if (alu_res.borrow) begin
					rem_q <= {rem_q[RATE_W-2:0], acc_q[DIV_STEPS-1]};
				end else begin
					rem_q <= alu_res.sum[RATE_W-1:0];
				end
				acc_q <= {acc_q[ALU_W-2:0], ~alu_res.borrow};
				step_q <= step_q - STEP_W'(1);
			end
			ST_ELAP: begin
				elap_q <= alu_res.sum;
				ge_q <= ~alu_res.borrow;
			end
			ST_AHEAD: ahead_q <= alu_res.sum;
			ST_MAX: sleep_q <= alu_res.borrow ? max_q : ahead_q[SLEEP_W-1:0];
			ST_STRK: begin
				diff_q <= alu_res.sum[TW-1:0];
				grt_q <= WIDE_TIME && alu_res.borrow;
			end
			ST_LIM: add_one_q <= streak_hit;
			default: ;
		endcase
	end

	// output register: load on finish, drop on a taken beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sleep_q <= sleep_q;
			out_one_q <= add_one_q;
			out_all_q <= add_all_q;
			out_count_q <= count_q;
		end
	end

`ifndef ASSERT_OFF
	a_div_rem_below_rate: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < rate_q))
		else $error("division remainder not below rate");

	a_one_request_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.add_worker && result.add_all_workers))
		else $error("both worker requests set");

	a_add_worker_no_sleep: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.add_worker) |-> (result.pause_us == '0))
		else $error("extra worker requested with a sleep");

	a_sleep_capped: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.pause_us <= max_q))
		else $error("sleep above cap");

	a_count_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INC) |=> (count_q == $past(count_q) + COUNT_W'(1)))
		else $error("item count did not advance by one");
`endif

endmodule

`default_nettype wire
